// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

	// Header control codes and the largest data length a header may carry.
	localparam logic [15:0] CODE_FINISH = 16'd32894;
	localparam logic [15:0] CODE_CLOSE  = 16'd32891;
	localparam logic [15:0] DATA_MAX    = 16'd32889;

	// Receive buffer size; the reset payload limit leaves room for the header.
	localparam int unsigned BUFFER_BYTES = 2000;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'(BUFFER_BYTES - 2);

	// Event codes carried in event_kind.
	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_CLOSE   = 3'd2;
	localparam logic [2:0] KIND_FINISH  = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_HDR_HI  = 2'd0,
		PH_HDR_LO  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	// Input register contents handed to the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
	} stage_t;

	// One result item.
	typedef struct packed {
		logic [7:0] payload_byte;
		logic [2:0] event_kind;
		logic       frame_last;
	} result_t;

endpackage

// ===== hdl/lpd_rx_if.sv =====
interface lpd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/lpd_ev_if.sv =====
interface lpd_ev_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [2:0] event_kind;
	logic       frame_last;

	modport source (output valid, output payload_byte, output event_kind, output frame_last,
		input ready);
	modport sink (input valid, input payload_byte, input event_kind, input frame_last,
		output ready);
endinterface

// ===== hdl/lpd_in_stage.sv =====
module lpd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	lpd_rx_if.sink          rx,
	input  logic            take,
	output lpd_pkg::stage_t stage_s1
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// The register takes a new request whenever it is empty or being drained.
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	// Byte storage needs no reset.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign stage_s1.valid   = valid_s1;
	assign stage_s1.rx_byte = byte_s1;

endmodule

// ===== hdl/lpd_parser.sv =====
module lpd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  lpd_pkg::stage_t stage_s1,
	output logic            take,
	lpd_ev_if.source        ev
);

	lpd_pkg::phase_t  phase_q, phase_d;
	logic [7:0]       hdr_hi_q, hdr_hi_d;
	logic [15:0]      rem_q, rem_d;
	logic [15:0]      max_q;
	logic [15:0]      len;
	logic             len_ok;
	logic             valid_s2;
	lpd_pkg::result_t res_s2, res_d;

	// A byte moves on when the result register is empty or being read.
	assign take = stage_s1.valid && (!valid_s2 || ev.ready);

	// Full header value once the second byte arrives.
	assign len    = {hdr_hi_q, stage_s1.rx_byte};
	assign len_ok = (len != lpd_pkg::CODE_FINISH) && (len != lpd_pkg::CODE_CLOSE) &&
		(len <= lpd_pkg::DATA_MAX) && (len != 16'd0) && (len <= max_q);

	// Next parser state.
	always_comb begin
		phase_d  = phase_q;
		hdr_hi_d = hdr_hi_q;
		rem_d    = rem_q;
		unique case (phase_q)
			lpd_pkg::PH_HDR_LO: begin
				phase_d = lpd_pkg::PH_HDR_HI;
				if (len_ok) begin
					rem_d   = len;
					phase_d = lpd_pkg::PH_PAYLOAD;
				end
			end
			lpd_pkg::PH_PAYLOAD: begin
				rem_d = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
				if (rem_q <= 16'd1) begin
					phase_d = lpd_pkg::PH_HDR_HI;
				end
			end
			default: begin
				hdr_hi_d = stage_s1.rx_byte;
				phase_d  = lpd_pkg::PH_HDR_LO;
			end
		endcase
	end

	// Result for the byte in the input register.
	always_comb begin
		res_d.payload_byte = 8'd0;
		res_d.event_kind   = lpd_pkg::KIND_HEADER;
		res_d.frame_last   = 1'b0;
		unique case (phase_q)
			lpd_pkg::PH_HDR_LO: begin
				if (len == lpd_pkg::CODE_FINISH) begin
					res_d.event_kind = lpd_pkg::KIND_FINISH;
				end else if (len == lpd_pkg::CODE_CLOSE) begin
					res_d.event_kind = lpd_pkg::KIND_CLOSE;
				end else if (!len_ok) begin
					res_d.event_kind = lpd_pkg::KIND_ERROR;
				end
			end
			lpd_pkg::PH_PAYLOAD: begin
				res_d.payload_byte = stage_s1.rx_byte;
				res_d.event_kind   = lpd_pkg::KIND_PAYLOAD;
				res_d.frame_last   = (rem_q <= 16'd1);
			end
			default: begin
				res_d.event_kind = lpd_pkg::KIND_HEADER;
			end
		endcase
	end

	// Parser state and the payload limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lpd_pkg::PH_HDR_HI;
			hdr_hi_q <= 8'd0;
			rem_q    <= 16'd0;
			max_q    <= lpd_pkg::MAX_PAYLOAD_RST;
		end else begin
			if (take) begin
				phase_q  <= phase_d;
				hdr_hi_q <= hdr_hi_d;
				rem_q    <= rem_d;
			end
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || ev.ready) begin
			valid_s2 <= stage_s1.valid;
		end
	end

	// Result payload needs no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res_d;
		end
	end

	assign ev.valid        = valid_s2;
	assign ev.payload_byte = res_s2.payload_byte;
	assign ev.event_kind   = res_s2.event_kind;
	assign ev.frame_last   = res_s2.frame_last;

endmodule

// ===== hdl/length_prefixed_deframer.sv =====
// Length-prefixed deframer: takes one link byte per request on rx and returns exactly one
// event per byte on ev, in order. Each frame is a 16-bit big-endian length header and that
// many payload bytes; header bytes report kind 0, payload bytes kind 1 with frame_last on the
// final byte, and the close, finish and error codes (2, 3, 4) return the parser to header
// search. A byte passes through an input register and a result register, so an event is
// offered on ev once its byte has moved on from the input register to the result register;
// one byte is accepted every cycle while ev keeps up; the single parser state update per
// byte sets that rate. cfg_wdata written with cfg_we sets the largest accepted payload
// length (1998 after reset); write it only while the block is idle.
module length_prefixed_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	lpd_rx_if.sink      rx,
	lpd_ev_if.source    ev
);

	lpd_pkg::stage_t stage_s1;
	logic            take;

	lpd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.stage_s1 (stage_s1)
	);

	lpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stage_s1  (stage_s1),
		.take      (take),
		.ev        (ev)
	);

`ifndef SYNTHESIS
	// A byte held in the input register is never dropped while the result side stalls.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		stage_s1.valid && !take |=> stage_s1.valid)
		else $error("input register lost a stalled byte");

	// Only a payload byte can end a frame.
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && ev.frame_last |-> ev.event_kind == lpd_pkg::KIND_PAYLOAD)
		else $error("frame_last set on a non-payload event");

	// Non-payload events carry a zero byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && ev.event_kind != lpd_pkg::KIND_PAYLOAD |-> ev.payload_byte == 8'd0)
		else $error("non-payload event carries a byte");
`endif

endmodule
